// ----- hdl/assert_macros.svh -----
// assertion macros for the checker in dtsb_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, masked while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ANY(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- hdl/dtsb_pkg.sv -----
// shared constants and calendar tables for the date to seconds converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dtsb_pkg;

   localparam int unsigned YEAR_W    = 16;
   localparam int unsigned MONTH_W   = 4;
   localparam int unsigned DAY_W     = 5;
   localparam int unsigned HOUR_W    = 5;
   localparam int unsigned MINUTE_W  = 6;
   localparam int unsigned SECOND_W  = 6;
   localparam int unsigned SECONDS_W = 32;

   localparam logic [YEAR_W-1:0] BASE_YEAR_RESET = 16'd1970;
   localparam int unsigned MAX_YEARS = 135;

   // floor(x / 100) as floor(floor(x / 4) / 25), reciprocal of 25 at 2^-20
   localparam int unsigned RECIP25_SHIFT = 20;
   localparam logic [15:0] RECIP25       = 16'd41945;
   localparam int unsigned QUOT100_W     = 10;

   // days before the first of a month in a common year
   function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] month);
      logic [8:0] d;
      case (month)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   // month length, zero for a month number that means nothing
   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
      logic [DAY_W-1:0] n;
      case (month)
         4'd2:                          n = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:       n = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7,
         4'd8, 4'd10, 4'd12:            n = 5'd31;
         default:                       n = 5'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/dtsb_if.sv -----
// valid/ready channel interfaces for date items and second counts
// depends on dtsb_pkg
`timescale 1ns / 1ps
`default_nettype none

interface dtsb_req_if import dtsb_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [YEAR_W-1:0]   year;
   logic [MONTH_W-1:0]  month;
   logic [DAY_W-1:0]    day;
   logic [HOUR_W-1:0]   hour;
   logic [MINUTE_W-1:0] minute;
   logic [SECOND_W-1:0] second;

   modport source (output valid, year, month, day, hour, minute, second, input ready);
   modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface

interface dtsb_rsp_if import dtsb_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [SECONDS_W-1:0] seconds;
   logic                 valid_res;

   modport source (output valid, seconds, valid_res, input ready);
   modport sink   (input valid, seconds, valid_res, output ready);
endinterface

`default_nettype wire

// ----- hdl/date_to_seconds_since_base_year.sv -----
// top level: calendar date and time to seconds since 1 January of a base year
// depends on dtsb_pkg, dtsb_if (req/rsp channels) and dtsb_div100
//
// usage
// - req_in carries one date item (year, month, day, hour, minute, second);
//   an item is taken at a rising edge with valid and ready both high
// - rsp_out returns one result item per date item, in order: seconds since
//   00:00:00 on 1 January of base_year, and valid_res
// - an item with a bad month, day, hour, minute or second, or a year outside
//   base_year .. base_year + 135, gives valid_res low and seconds zero
// - every count in the year window stays below 2^32, so none wraps
// - csr_we/csr_wdata write base_year (reset value 1970); write it only while
//   no item is in flight
// - an accepted item reaches rsp_out.valid through five register stages
//   (quotients by 100, leap/ceiling terms, leap count and time of day,
//   day count, final multiply by 86400), each taking one item per cycle unless stalled
// - throughput is one item per cycle while rsp_out.ready stays high
// - a receiver stall holds the result in the output stage; earlier stages
//   keep filling bubbles and req_in.ready drops only once all five are full
// - synchronous reset empties every stage; no results appear after reset
//   until new items are taken
`timescale 1ns / 1ps
`default_nettype none

module date_to_seconds_since_base_year import dtsb_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   dtsb_req_if.sink                  req_in,
   dtsb_rsp_if.source                rsp_out,
   input  wire logic                 csr_we,
   input  wire logic [YEAR_W-1:0]    csr_wdata
);

   // configuration register
   logic [YEAR_W-1:0] base_year_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_year_ff <= BASE_YEAR_RESET;
      end else if (csr_we) begin
         base_year_ff <= csr_wdata;
      end
   end

   // stage enables: a stage loads when it is empty or its successor loads
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   logic s1_en, s2_en, s3_en, s4_en, s5_en;

   assign s5_en = !s5_v_ff || rsp_out.ready;
   assign s4_en = !s4_v_ff || s5_en;
   assign s3_en = !s3_v_ff || s4_en;
   assign s2_en = !s2_v_ff || s3_en;
   assign s1_en = !s1_v_ff || s2_en;

   assign req_in.ready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else begin
         if (s1_en) s1_v_ff <= req_in.valid;
         if (s2_en) s2_v_ff <= s1_v_ff;
         if (s3_en) s3_v_ff <= s2_v_ff;
         if (s4_en) s4_v_ff <= s3_v_ff;
         if (s5_en) s5_v_ff <= s4_v_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: field range checks, year window, floor(year / 100)
   // ---------------------------------------------------------------
   logic [QUOT100_W-1:0] s1_fy_in, s1_fb_in;
   logic                 s1_ok_in;
   logic [YEAR_W:0]      s1_year_top;

   dtsb_div100 u_div_year (.value(req_in.year),   .quot(s1_fy_in));
   dtsb_div100 u_div_base (.value(base_year_ff),  .quot(s1_fb_in));

   // upper bound formed one bit wider so a high base year does not wrap
   assign s1_year_top = {1'b0, base_year_ff} + (YEAR_W+1)'(MAX_YEARS);

   assign s1_ok_in = (req_in.month >= MONTH_W'(1)) && (req_in.month <= MONTH_W'(12))
                  && (req_in.hour < HOUR_W'(24))
                  && (req_in.minute < MINUTE_W'(60))
                  && (req_in.second < SECOND_W'(60))
                  && (req_in.year >= base_year_ff)
                  && ({1'b0, req_in.year} <= s1_year_top);

   logic [YEAR_W-1:0]    s1_year_ff, s1_base_ff;
   logic [MONTH_W-1:0]   s1_month_ff;
   logic [DAY_W-1:0]     s1_day_ff;
   logic [HOUR_W-1:0]    s1_hour_ff;
   logic [MINUTE_W-1:0]  s1_minute_ff;
   logic [SECOND_W-1:0]  s1_second_ff;
   logic [QUOT100_W-1:0] s1_fy_ff, s1_fb_ff;
   logic                 s1_ok_ff;

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_year_ff   <= req_in.year;
         s1_base_ff   <= base_year_ff;
         s1_month_ff  <= req_in.month;
         s1_day_ff    <= req_in.day;
         s1_hour_ff   <= req_in.hour;
         s1_minute_ff <= req_in.minute;
         s1_second_ff <= req_in.second;
         s1_fy_ff     <= s1_fy_in;
         s1_fb_ff     <= s1_fb_in;
         s1_ok_ff     <= s1_ok_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: century tests, leap flag, ceil(n/4) and ceil(n/100)
   // leap years in [0, n) = ceil(n/4) - ceil(n/100) + ceil(n/400)
   // ---------------------------------------------------------------
   logic [16:0]          s2_y100, s2_b100;
   logic                 s2_y_cent, s2_b_cent;
   logic                 s2_leap_in;
   logic [YEAR_W-2:0]    s2_c4y_in, s2_c4b_in;
   logic [QUOT100_W:0]   s2_c100y_in, s2_c100b_in;
   logic [YEAR_W:0]      s2_y3, s2_b3;
   logic [7:0]           s2_dy_in;
   logic [YEAR_W-1:0]    s2_dy_full;

   assign s2_y100   = 17'(s1_fy_ff) * 17'd100;
   assign s2_b100   = 17'(s1_fb_ff) * 17'd100;
   assign s2_y_cent = (s2_y100 == {1'b0, s1_year_ff});
   assign s2_b_cent = (s2_b100 == {1'b0, s1_base_ff});

   // 4/100/400 rule, year 0 included
   assign s2_leap_in = (s1_year_ff[1:0] == 2'b00)
                    && (!s2_y_cent || (s1_fy_ff[1:0] == 2'b00));

   assign s2_y3       = {1'b0, s1_year_ff} + 17'd3;
   assign s2_b3       = {1'b0, s1_base_ff} + 17'd3;
   assign s2_c4y_in   = s2_y3[YEAR_W:2];
   assign s2_c4b_in   = s2_b3[YEAR_W:2];
   assign s2_c100y_in = {1'b0, s1_fy_ff} + (QUOT100_W+1)'(!s2_y_cent);
   assign s2_c100b_in = {1'b0, s1_fb_ff} + (QUOT100_W+1)'(!s2_b_cent);

   // year offset fits 8 bits whenever the window check passes
   assign s2_dy_full = s1_year_ff - s1_base_ff;
   assign s2_dy_in   = s2_dy_full[7:0];

   logic [MONTH_W-1:0]   s2_month_ff;
   logic [DAY_W-1:0]     s2_day_ff;
   logic [HOUR_W-1:0]    s2_hour_ff;
   logic [MINUTE_W-1:0]  s2_minute_ff;
   logic [SECOND_W-1:0]  s2_second_ff;
   logic                 s2_ok_ff, s2_leap_ff;
   logic [7:0]           s2_dy_ff;
   logic [YEAR_W-2:0]    s2_c4y_ff, s2_c4b_ff;
   logic [QUOT100_W:0]   s2_c100y_ff, s2_c100b_ff;

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_month_ff  <= s1_month_ff;
         s2_day_ff    <= s1_day_ff;
         s2_hour_ff   <= s1_hour_ff;
         s2_minute_ff <= s1_minute_ff;
         s2_second_ff <= s1_second_ff;
         s2_ok_ff     <= s1_ok_ff;
         s2_leap_ff   <= s2_leap_in;
         s2_dy_ff     <= s2_dy_in;
         s2_c4y_ff    <= s2_c4y_in;
         s2_c4b_ff    <= s2_c4b_in;
         s2_c100y_ff  <= s2_c100y_in;
         s2_c100b_ff  <= s2_c100b_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: leap count over the year span, day check, month offset,
   // time of day
   // ---------------------------------------------------------------
   logic [QUOT100_W:0]   s3_y400_sum, s3_b400_sum;
   logic [YEAR_W-1:0]    s3_cy, s3_cb, s3_span;
   logic [7:0]           s3_leaps_in;
   logic                 s3_ok_in;
   logic [8:0]           s3_moff_in;
   logic [16:0]          s3_tod_in;

   assign s3_y400_sum = s2_c100y_ff + (QUOT100_W+1)'(3);
   assign s3_b400_sum = s2_c100b_ff + (QUOT100_W+1)'(3);
   assign s3_cy = {1'b0, s2_c4y_ff} - YEAR_W'(s2_c100y_ff)
                + YEAR_W'(s3_y400_sum[QUOT100_W:2]);
   assign s3_cb = {1'b0, s2_c4b_ff} - YEAR_W'(s2_c100b_ff)
                + YEAR_W'(s3_b400_sum[QUOT100_W:2]);
   assign s3_span     = s3_cy - s3_cb;
   assign s3_leaps_in = s3_span[7:0];

   assign s3_ok_in = s2_ok_ff && (s2_day_ff != DAY_W'(0))
                  && (s2_day_ff <= month_length(s2_month_ff, s2_leap_ff));

   // leap day counts once the month is past February
   assign s3_moff_in = days_before_month(s2_month_ff)
                     + 9'(s2_leap_ff && (s2_month_ff > MONTH_W'(2)));

   assign s3_tod_in = 17'(s2_hour_ff) * 17'd3600
                    + 17'(s2_minute_ff) * 17'd60
                    + 17'(s2_second_ff);

   logic                 s3_ok_ff;
   logic [7:0]           s3_dy_ff, s3_leaps_ff;
   logic [8:0]           s3_moff_ff;
   logic [DAY_W-1:0]     s3_day_ff;
   logic [16:0]          s3_tod_ff;

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_ok_ff    <= s3_ok_in;
         s3_dy_ff    <= s2_dy_ff;
         s3_leaps_ff <= s3_leaps_in;
         s3_moff_ff  <= s3_moff_in;
         s3_day_ff   <= s2_day_ff;
         s3_tod_ff   <= s3_tod_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 4: whole days since the base year start
   // ---------------------------------------------------------------
   logic [16:0] s4_days_in;

   assign s4_days_in = 17'(s3_dy_ff) * 17'd365 + 17'(s3_leaps_ff)
                     + 17'(s3_moff_ff) + 17'(s3_day_ff) - 17'd1;

   logic        s4_ok_ff;
   logic [15:0] s4_days_ff;
   logic [16:0] s4_tod_ff;

   always_ff @(posedge clock) begin
      if (s4_en) begin
         s4_ok_ff   <= s3_ok_ff;
         s4_days_ff <= s4_days_in[15:0];
         s4_tod_ff  <= s3_tod_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 5: days * 86400 + time of day, zero if rejected, 32 bits, output reg
   // ---------------------------------------------------------------
   logic [32:0]          s5_total;
   logic [SECONDS_W-1:0] s5_seconds_in;

   assign s5_total      = 33'(s4_days_ff) * 33'd86400 + 33'(s4_tod_ff);
   assign s5_seconds_in = s4_ok_ff ? s5_total[SECONDS_W-1:0] : '0;

   logic [SECONDS_W-1:0] s5_seconds_ff;
   logic                 s5_valid_res_ff;

   always_ff @(posedge clock) begin
      if (s5_en) begin
         s5_seconds_ff   <= s5_seconds_in;
         s5_valid_res_ff <= s4_ok_ff;
      end
   end

   assign rsp_out.valid     = s5_v_ff;
   assign rsp_out.seconds   = s5_seconds_ff;
   assign rsp_out.valid_res = s5_valid_res_ff;

endmodule

`default_nettype wire

// ----- hdl/dtsb_div100.sv -----
// floor division of a 16-bit year by 100 through a reciprocal multiply
// depends on dtsb_pkg
`timescale 1ns / 1ps
`default_nettype none

module dtsb_div100 import dtsb_pkg::*; (
   input  wire logic [YEAR_W-1:0]    value,
   output logic      [QUOT100_W-1:0] quot
);

   logic [YEAR_W-3:0] quarter;
   logic [29:0]       product;

   // value / 4 first, then exact / 25 for every 14-bit quarter
   assign quarter = value[YEAR_W-1:2];
   assign product = 30'(quarter) * 30'(RECIP25);
   assign quot    = product[RECIP25_SHIFT +: QUOT100_W];

endmodule

`default_nettype wire

// ----- hdl/dtsb_checker.sv -----
// port-level checks on the result channel of the date to seconds converter
// depends on dtsb_pkg and assert_macros.svh; bound to the top level below
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dtsb_checker import dtsb_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [SECONDS_W-1:0] rsp_seconds,
   input wire logic                 rsp_valid_res
);

   // a rejected item reports zero seconds
   `ASSERT_IMPLY(a_zero_when_rejected, clock, reset, rsp_valid && !rsp_valid_res, rsp_seconds == '0)

   // reset empties the pipeline, so no item follows a reset cycle
   `ASSERT_NEXT_ANY(a_empty_after_reset, clock, reset, !rsp_valid)

   // a stalled item stays offered
   `ASSERT_NEXT(a_valid_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a stalled item keeps its payload
   `ASSERT_NEXT(a_payload_holds, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_seconds) && $stable(rsp_valid_res))

endmodule

bind date_to_seconds_since_base_year dtsb_checker u_dtsb_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_out.valid),
   .rsp_ready     (rsp_out.ready),
   .rsp_seconds   (rsp_out.seconds),
   .rsp_valid_res (rsp_out.valid_res)
);

`default_nettype wire

// ----- sim/testbench.sv -----
// self-checking testbench for date_to_seconds_since_base_year
// depends on dtsb_pkg, dtsb_if and the converter rtl; predicts every result in-line
`timescale 1ns / 1ps

module testbench;
   import dtsb_pkg::*;

   // run control
   localparam int unsigned RESET_CYCLES  = 11;
   localparam int unsigned SETTLE_CYCLES = 8;       // pipeline is 5 deep, plus margin
   localparam int unsigned DRAIN_CYCLES  = 20;
   localparam int unsigned LONG_HOLD     = 80;      // long hold-off so all five stages can fill
   localparam int unsigned LIMIT_CYCLES  = 300000;
   localparam int unsigned SECS_PER_DAY  = 86400;

   // which field a broken date gets wrong
   typedef enum int unsigned {
      BAD_YEAR,
      BAD_MONTH,
      BAD_DAY,
      BAD_HOUR,
      BAD_MINUTE,
      BAD_SECOND
   } bad_field_type;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } date_item_type;

   typedef struct packed {
      logic [SECONDS_W-1:0] seconds;
      logic                 valid_res;
   } count_item_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [YEAR_W-1:0] csr_wdata;

   dtsb_req_if req_if ();
   dtsb_rsp_if rsp_if ();

   date_to_seconds_since_base_year dut (
      .clock     (clock),
      .reset     (reset),
      .req_in    (req_if.sink),
      .rsp_out   (rsp_if.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // dates waiting to be offered, and second counts owed by the block in order
   date_item_type  dates_pending [$];
   count_item_type counts_due [$];

   // local copy of the base year register
   logic [YEAR_W-1:0] base_year_copy = BASE_YEAR_RESET;

   // idling control, set by the stimulus process
   logic src_gaps_on = 1'b1;
   logic snk_gaps_on = 1'b1;
   logic hold_armed  = 1'b0;

   date_item_type offered;
   int unsigned src_gap_left  = 0;
   int unsigned snk_stall_left = 0;
   int unsigned hold_left     = 0;
   logic        hold_done     = 1'b0;

   int unsigned n_sent     = 0;
   int unsigned n_checked  = 0;
   int unsigned n_good     = 0;
   int unsigned n_rejected = 0;
   int unsigned n_fail     = 0;
   int unsigned n_settings = 1;
   int unsigned cycle_count = 0;

   // -------------------------------------------------------------------------
   // calendar predictor
   // -------------------------------------------------------------------------

   // gregorian 4/100/400 rule, year 0 counts as leap
   function automatic logic is_leap(input int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int unsigned days_in(input logic [MONTH_W-1:0] m, input logic leap);
      int unsigned n;
      case (m)
         4'd2:                             n = leap ? 29 : 28;
         4'd4, 4'd6, 4'd9, 4'd11:          n = 30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
         4'd10, 4'd12:                     n = 31;
         default:                          n = 0;
      endcase
      return n;
   endfunction

   // seconds since 1 january of base, zero and flag low for anything out of range;
   // the count is kept in a 32-bit accumulator, which the window never overflows
   function automatic count_item_type date_to_count(input date_item_type d,
                                                    input logic [YEAR_W-1:0] base);
      count_item_type       r;
      int unsigned          last_year;
      int unsigned          y;
      int unsigned          m;
      logic                 leap;
      logic                 ok;
      logic [SECONDS_W-1:0] acc;
      leap      = is_leap(d.year);
      last_year = base + MAX_YEARS;   // 32-bit sum, no wrap for high bases
      ok        = 1'b1;
      if (d.month < 1 || d.month > 12)
         ok = 1'b0;
      else if (d.day < 1 || d.day > days_in(d.month, leap))
         ok = 1'b0;
      if (d.hour >= 24 || d.minute >= 60 || d.second >= 60)
         ok = 1'b0;
      if (d.year < base || d.year > last_year)
         ok = 1'b0;
      acc = '0;
      if (ok) begin
         for (y = base; y < d.year; y++)
            acc += SECS_PER_DAY * (is_leap(y) ? 366 : 365);
         for (m = 1; m < d.month; m++)
            acc += days_in(m, leap) * SECS_PER_DAY;
         acc += (d.day - 1) * SECS_PER_DAY;
         acc += d.hour * 3600;
         acc += d.minute * 60;
         acc += d.second;
      end
      r.seconds   = acc;
      r.valid_res = ok;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // stimulus helpers
   // -------------------------------------------------------------------------

   function automatic date_item_type make_date(input int unsigned y, input int unsigned mo,
                                               input int unsigned dd, input int unsigned h,
                                               input int unsigned mi, input int unsigned s);
      date_item_type d;
      d.year   = y;
      d.month  = mo;
      d.day    = dd;
      d.hour   = h;
      d.minute = mi;
      d.second = s;
      return d;
   endfunction

   // mostly zero, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // well-formed dates inside the window most of the time, then one broken
   // field, then raw noise over the full field widths
   function automatic date_item_type random_date(input logic [YEAR_W-1:0] base);
      date_item_type d;
      int unsigned   top;
      int unsigned   len;
      int unsigned   r;
      logic          below_ok;
      logic          above_ok;
      bad_field_type bad;
      top = base + MAX_YEARS;
      if (top > 65535)
         top = 65535;
      r = $urandom_range(0, 99);
      if (r >= 85) begin
         d.year   = $urandom_range(0, 65535);
         d.month  = $urandom_range(0, 15);
         d.day    = $urandom_range(0, 31);
         d.hour   = $urandom_range(0, 31);
         d.minute = $urandom_range(0, 63);
         d.second = $urandom_range(0, 63);
         return d;
      end
      case ($urandom_range(0, 4))
         0:       d.year = base;
         1:       d.year = top;
         default: d.year = $urandom_range(base, top);
      endcase
      d.month  = $urandom_range(1, 12);
      len      = days_in(d.month, is_leap(d.year));
      d.day    = ($urandom_range(0, 5) == 0) ? len : $urandom_range(1, len);
      d.hour   = ($urandom_range(0, 5) == 0) ? 23 : $urandom_range(0, 23);
      d.minute = ($urandom_range(0, 5) == 0) ? 59 : $urandom_range(0, 59);
      d.second = ($urandom_range(0, 5) == 0) ? 59 : $urandom_range(0, 59);
      if (r >= 70) begin
         bad = bad_field_type'($urandom_range(0, 5));
         case (bad)
            BAD_YEAR: begin
               below_ok = (base != 0);
               above_ok = (base + MAX_YEARS + 1 <= 65535);
               if (below_ok && (!above_ok || $urandom_range(0, 1) == 0))
                  d.year = $urandom_range(0, 1) ? base - 1 : $urandom_range(0, base - 1);
               else
                  d.year = $urandom_range(0, 1) ? base + MAX_YEARS + 1
                                                : $urandom_range(base + MAX_YEARS + 1, 65535);
            end
            BAD_MONTH: begin
               r       = $urandom_range(0, 3);
               d.month = (r == 0) ? 0 : 12 + r;
            end
            BAD_DAY:    d.day = (len < 31 && $urandom_range(0, 1)) ? $urandom_range(len + 1, 31)
                                                                   : 0;
            BAD_HOUR:   d.hour   = $urandom_range(24, 31);
            BAD_MINUTE: d.minute = $urandom_range(60, 63);
            BAD_SECOND: d.second = $urandom_range(60, 63);
            default: ;
         endcase
      end
      return d;
   endfunction

   task automatic queue_random(input int unsigned n);
      int unsigned i;
      for (i = 0; i < n; i++)
         dates_pending.push_back(random_date(base_year_copy));
   endtask

   // sender stays quiet until every owed count is back, then the pipe is
   // given time to empty before the register changes; the idle test runs at
   // the falling edge so every update of the rising edge has settled
   task automatic wait_idle();
      while (dates_pending.size() != 0 || req_if.valid || counts_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_base_year(input logic [YEAR_W-1:0] value);
      wait_idle();
      @(posedge clock);
      csr_we         <= 1'b1;
      csr_wdata      <= value;
      base_year_copy  = value;
      @(posedge clock);
      csr_we         <= 1'b0;
      n_settings++;
   endtask

   // -------------------------------------------------------------------------
   // clock and cycle limit
   // -------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop so a hung handshake cannot run forever
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d counts still owed", cycle_count,
                  counts_due.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // driver: offers queued dates, holds each until taken, then maybe idles
   // -------------------------------------------------------------------------

   always @(posedge clock) begin : driver
      logic          took;
      date_item_type nxt;
      took = req_if.valid && req_if.ready;
      if (reset) begin
         req_if.valid <= 1'b0;
         src_gap_left  = 0;
      end else begin
         // the count is predicted with the register value in force at acceptance
         if (took) begin
            counts_due.push_back(date_to_count(offered, base_year_copy));
            n_sent++;
            src_gap_left = src_gaps_on ? pick_gap() : 0;
         end
         if (req_if.valid && !took) begin
            // item still on offer, payload and valid stay put
         end else if (src_gap_left > 0) begin
            src_gap_left--;
            req_if.valid <= 1'b0;
         end else if (dates_pending.size() != 0) begin
            nxt            = dates_pending.pop_front();
            offered        = nxt;
            req_if.year   <= nxt.year;
            req_if.month  <= nxt.month;
            req_if.day    <= nxt.day;
            req_if.hour   <= nxt.hour;
            req_if.minute <= nxt.minute;
            req_if.second <= nxt.second;
            req_if.valid  <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // receiver: random stalls, plus one long hold-off so the pipe backs up
   // -------------------------------------------------------------------------

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_if.ready  <= 1'b0;
         snk_stall_left = 0;
         hold_left      = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (hold_armed && !hold_done) begin
         hold_left    = LONG_HOLD - 1;
         hold_done    = 1'b1;
         rsp_if.ready <= 1'b0;
      end else if (snk_stall_left > 0) begin
         snk_stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (snk_gaps_on && $urandom_range(0, 99) < 25) begin
         snk_stall_left = pick_gap();
         rsp_if.ready  <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // monitor: every taken result against the oldest owed count
   // -------------------------------------------------------------------------

   always @(posedge clock) begin : monitor
      count_item_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (counts_due.size() == 0) begin
            $error("unexpected result item: seconds %0d valid_res %0b",
                   rsp_if.seconds, rsp_if.valid_res);
            n_fail++;
         end else begin
            want = counts_due.pop_front();
            n_checked++;
            if (rsp_if.seconds !== want.seconds) begin
               $error("seconds mismatch: expected %0d, actual %0d",
                      want.seconds, rsp_if.seconds);
               n_fail++;
            end
            if (rsp_if.valid_res !== want.valid_res) begin
               $error("valid_res mismatch: expected %0b, actual %0b",
                      want.valid_res, rsp_if.valid_res);
               n_fail++;
            end
            if (want.valid_res)
               n_good++;
            else
               n_rejected++;
         end
      end
   end

   // -------------------------------------------------------------------------
   // stimulus: directed corners at the reset base year, then random phases
   // over several base years, each register change made with the pipe empty
   // -------------------------------------------------------------------------

   initial begin : stimulus
      // every block input known from time zero
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      req_if.valid  = 1'b0;
      req_if.year   = '0;
      req_if.month  = '0;
      req_if.day    = '0;
      req_if.hour   = '0;
      req_if.minute = '0;
      req_if.second = '0;
      rsp_if.ready  = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset base year 1970: window edges
      dates_pending.push_back(make_date(1970, 1, 1, 0, 0, 0));
      dates_pending.push_back(make_date(2105, 12, 31, 23, 59, 59));   // last second of the window, just below 2^32
      dates_pending.push_back(make_date(2106, 1, 1, 0, 0, 0));        // one past the window
      dates_pending.push_back(make_date(1969, 12, 31, 23, 59, 59));   // before the base
      // leap rule: 400s leap, 100s common, 4s leap, others common
      dates_pending.push_back(make_date(2000, 2, 29, 12, 0, 0));
      dates_pending.push_back(make_date(2100, 2, 29, 0, 0, 0));
      dates_pending.push_back(make_date(2024, 2, 29, 6, 30, 15));
      dates_pending.push_back(make_date(2023, 2, 29, 0, 0, 0));
      // month and day out of range, then the last day of January
      dates_pending.push_back(make_date(2001, 0, 10, 0, 0, 0));
      dates_pending.push_back(make_date(2001, 13, 10, 0, 0, 0));
      dates_pending.push_back(make_date(2001, 15, 10, 0, 0, 0));
      dates_pending.push_back(make_date(2001, 3, 0, 0, 0, 0));
      dates_pending.push_back(make_date(2001, 4, 31, 0, 0, 0));
      dates_pending.push_back(make_date(2001, 1, 31, 0, 0, 0));
      // time of day out of range, each at its first bad value and at all ones
      dates_pending.push_back(make_date(1999, 6, 15, 24, 0, 0));
      dates_pending.push_back(make_date(1999, 6, 15, 31, 0, 0));
      dates_pending.push_back(make_date(1999, 6, 15, 0, 60, 0));
      dates_pending.push_back(make_date(1999, 6, 15, 0, 63, 0));
      dates_pending.push_back(make_date(1999, 6, 15, 0, 0, 60));
      dates_pending.push_back(make_date(1999, 6, 15, 0, 0, 63));
      // all fields zero and all fields ones
      dates_pending.push_back(make_date(0, 0, 0, 0, 0, 0));
      dates_pending.push_back(make_date(65535, 15, 31, 31, 63, 63));
      queue_random(80);

      // lowest base: year 0 is leap, window 0..135
      set_base_year(16'd0);
      dates_pending.push_back(make_date(0, 2, 29, 12, 0, 0));
      dates_pending.push_back(make_date(136, 1, 1, 0, 0, 0));
      queue_random(70);

      // highest base: only year 65535 fits, base + 135 must not wrap
      set_base_year(16'hFFFF);
      dates_pending.push_back(make_date(65535, 12, 31, 23, 59, 59));
      queue_random(60);

      // high base with no idling on either side: back-to-back bursts
      set_base_year(16'd65400);
      src_gaps_on = 1'b0;
      snk_gaps_on = 1'b0;
      queue_random(70);

      // long receiver hold-off while the sender keeps offering
      set_base_year(16'd2000);
      src_gaps_on = 1'b1;
      snk_gaps_on = 1'b1;
      hold_armed  = 1'b1;
      queue_random(80);

      // arbitrary base
      set_base_year($urandom_range(0, 65535));
      queue_random(70);

      // back to the reset value, written explicitly this time
      set_base_year(BASE_YEAR_RESET);
      queue_random(70);

      // drain: nothing on offer, nothing owed, then a few quiet cycles
      while (dates_pending.size() != 0 || req_if.valid || counts_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("converted %0d dates under %0d base-year settings: %0d in range, %0d rejected",
               n_checked, n_settings, n_good, n_rejected);
      $display("window edges, leap rules, field overruns, bursts and a long output stall hit");
      if (n_fail == 0 && n_checked == n_sent) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/dtsb_pkg.sv
hdl/dtsb_if.sv
hdl/dtsb_div100.sv
hdl/date_to_seconds_since_base_year.sv
hdl/dtsb_checker.sv
sim/testbench.sv
